[sv/fvca_pkg.sv]
`default_nettype none
package fvca_pkg;

    localparam int VERTICES   = 4096;
    localparam int COUNT_BITS = 16;

    localparam int ADDR_W  = $clog2(VERTICES);
    localparam int VTX_W   = 12;
    localparam int COLOR_W = 8;
    localparam int QUOT_W  = COLOR_W;
    localparam int SUM_W   = COLOR_W + COUNT_BITS;
    localparam int FACE_W  = 16;
    localparam int TRI_W   = 11;
    // wide enough for 3 * (2^TRI_W - 1) + 2
    localparam int IDX_W   = 14;
    localparam int STEP_W  = $clog2(QUOT_W);

    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMPLICIT     = 1'd1;
    localparam logic [CFG_W-1:0]     VCOUNT_RESET     = 13'd4096;

    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam logic [1:0] SLOT_A = 2'd0;
    localparam logic [1:0] SLOT_B = 2'd1;
    localparam logic [1:0] SLOT_C = 2'd2;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic               kind;
        logic [VTX_W-1:0]   vertex_a;
        logic [VTX_W-1:0]   vertex_b;
        logic [VTX_W-1:0]   vertex_c;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } in_item_t;

    typedef struct packed {
        logic [VTX_W-1:0]   vertex;
        logic [COLOR_W-1:0] avg_red;
        logic [COLOR_W-1:0] avg_green;
        logic [COLOR_W-1:0] avg_blue;
        logic [FACE_W-1:0]  face_count;
        logic               covered;
    } out_item_t;

    typedef struct packed {
        logic [2:0][SUM_W-1:0]  sum;
        logic [COUNT_BITS-1:0]  count;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic              clr;
        logic              load;
        logic              rd_en;
        logic [1:0]        rd_slot;
        logic              acc_wr;
        logic              rd_latch;
        logic              div_step;
        logic [STEP_W-1:0] div_bit;
        logic              out_load;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic in_kind;
        logic out_free;
    } stat_t;

    function automatic logic index_ok(input logic [IDX_W-1:0] idx,
                                      input logic [CFG_W-1:0] vcount);
        logic lo;
        logic hi;
        lo = 32'(idx) < 32'(vcount);
        hi = 32'(idx) < 32'(VERTICES);
        return lo && hi;
    endfunction

endpackage
`default_nettype wire

[sv/fvca_ram.sv]
`default_nettype none
module fvca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

[sv/fvca_ctrl.sv]
`default_nettype none
module fvca_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire fvca_pkg::stat_t stat,
    output fvca_pkg::cmd_t      cmd
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_TRI_A = 3'd2;
    localparam logic [2:0] ST_TRI_B = 3'd3;
    localparam logic [2:0] ST_TRI_C = 3'd4;
    localparam logic [2:0] ST_LATCH = 3'd5;
    localparam logic [2:0] ST_DIV   = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    localparam logic [fvca_pkg::STEP_W-1:0] STEP_LAST =
        fvca_pkg::STEP_W'(fvca_pkg::QUOT_W - 1);

    logic [2:0]                  state_reg, state_next;
    logic [fvca_pkg::STEP_W-1:0] step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        cmd        = '0;
        s_ready    = 1'b0;
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr = 1'b1;
                if (stat.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    // fetch the first vertex in the accept cycle
                    cmd.load    = 1'b1;
                    cmd.rd_en   = 1'b1;
                    cmd.rd_slot = fvca_pkg::SLOT_A;
                    state_next  = (stat.in_kind == fvca_pkg::KIND_READ) ? ST_LATCH
                                                                        : ST_TRI_A;
                end
            end
            ST_TRI_A: begin
                cmd.acc_wr  = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.rd_slot = fvca_pkg::SLOT_B;
                state_next  = ST_TRI_B;
            end
            ST_TRI_B: begin
                cmd.acc_wr  = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.rd_slot = fvca_pkg::SLOT_C;
                state_next  = ST_TRI_C;
            end
            ST_TRI_C: begin
                cmd.acc_wr = 1'b1;
                state_next = ST_IDLE;
            end
            ST_LATCH: begin
                cmd.rd_latch = 1'b1;
                step_next    = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cmd.div_bit  = STEP_LAST - step_reg;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_LAST) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
        endcase
    end

endmodule
`default_nettype wire

[sv/fvca_dp.sv]
`default_nettype none
module fvca_dp (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire fvca_pkg::cmd_t                    cmd,
    output fvca_pkg::stat_t                        stat,
    input  wire fvca_pkg::in_item_t                s_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output fvca_pkg::out_item_t                    m_data,
    input  wire logic                              cfg_we,
    input  wire logic [fvca_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [fvca_pkg::CFG_W-1:0]        cfg_data
);

    localparam int AW = fvca_pkg::ADDR_W;
    localparam int IW = fvca_pkg::IDX_W;
    localparam int SW = fvca_pkg::SUM_W;
    localparam int QW = fvca_pkg::QUOT_W;
    localparam int CB = fvca_pkg::COUNT_BITS;

    // configuration and running state
    logic [fvca_pkg::CFG_W-1:0] vcount_reg;
    logic                       implicit_reg;
    logic [fvca_pkg::TRI_W-1:0] tri_cnt_reg;
    logic [AW-1:0]              clr_cnt_reg;

    // item registers
    fvca_pkg::in_item_t item_reg;
    logic [AW-1:0]      addr_reg [3];
    logic               ok_reg   [3];
    logic [1:0]         rd_slot_reg;

    // write forwarding for a read that sees the write of the same edge
    logic                    fwd_valid_reg;
    logic [AW-1:0]           fwd_addr_reg;
    fvca_pkg::entry_t        fwd_data_reg;
    logic [AW-1:0]           rd_addr_reg;

    // divider
    logic [2:0][SW-1:0] rem_reg;
    logic [2:0][QW-1:0] quot_reg;
    logic [CB-1:0]      dcount_reg;
    logic               dok_reg;

    logic                m_valid_reg;
    fvca_pkg::out_item_t m_data_reg;

    // memory port signals
    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    fvca_pkg::entry_t             ram_wdata;
    logic [AW-1:0]                ram_raddr;
    logic [fvca_pkg::ENTRY_W-1:0] ram_rdata;

    logic [IW-1:0]      base;
    logic [IW-1:0]      idx_next [3];
    logic               ok_next  [3];
    fvca_pkg::entry_t   cur;
    fvca_pkg::entry_t   upd;
    logic [2:0][QW-1:0] rgb;
    logic [SW-1:0]      trial;

    fvca_ram #(
        .WIDTH (fvca_pkg::ENTRY_W),
        .DEPTH (fvca_pkg::VERTICES)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd_en),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // vertex indices of the incoming item
    always_comb begin
        base = IW'({tri_cnt_reg, 1'b0}) + IW'(tri_cnt_reg);
        if (implicit_reg) begin
            idx_next[0] = base;
            idx_next[1] = base + IW'(1);
            idx_next[2] = base + IW'(2);
        end else begin
            idx_next[0] = IW'(s_data.vertex_a);
            idx_next[1] = IW'(s_data.vertex_b);
            idx_next[2] = IW'(s_data.vertex_c);
        end
        // a read item always names its vertex directly
        if (s_data.kind == fvca_pkg::KIND_READ) begin
            idx_next[0] = IW'(s_data.vertex_a);
        end
        for (int i = 0; i < 3; i++) begin
            ok_next[i] = fvca_pkg::index_ok(idx_next[i], vcount_reg);
        end
    end

    assign ram_raddr = cmd.load ? AW'(idx_next[0]) : addr_reg[cmd.rd_slot];

    always_comb begin
        cur = fvca_pkg::entry_t'(ram_rdata);
        if (fwd_valid_reg && (fwd_addr_reg == rd_addr_reg)) begin
            cur = fwd_data_reg;
        end
        rgb = {item_reg.red, item_reg.green, item_reg.blue};
        upd = cur;
        for (int c = 0; c < 3; c++) begin
            upd.sum[c] = cur.sum[c] + SW'(rgb[c]);
        end
        upd.count = cur.count + 1'b1;
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = clr_cnt_reg;
        ram_wdata = '0;
        if (cmd.clr) begin
            ram_we = 1'b1;
        end else if (cmd.acc_wr) begin
            ram_waddr = addr_reg[rd_slot_reg];
            ram_wdata = upd;
            // skip out-of-range and saturated vertices
            ram_we    = ok_reg[rd_slot_reg] && (cur.count != fvca_pkg::COUNT_MAX);
        end else if (cmd.rd_latch) begin
            ram_waddr = addr_reg[0];
            ram_we    = ok_reg[0];
        end
    end

    assign stat.clr_last = (clr_cnt_reg == AW'(fvca_pkg::VERTICES - 1));
    assign stat.in_kind  = s_data.kind;
    assign stat.out_free = !m_valid_reg || m_ready;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg    <= fvca_pkg::VCOUNT_RESET;
            implicit_reg  <= 1'b0;
            tri_cnt_reg   <= '0;
            clr_cnt_reg   <= '0;
            fwd_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    fvca_pkg::REG_VERTEX_COUNT: vcount_reg   <= cfg_data;
                    fvca_pkg::REG_IMPLICIT:     implicit_reg <= cfg_data[0];
                endcase
            end
            if (cmd.load && (s_data.kind == fvca_pkg::KIND_ADD)) begin
                tri_cnt_reg <= tri_cnt_reg + 1'b1;
            end
            if (cmd.clr) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            fwd_valid_reg <= ram_we;
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        trial = SW'(dcount_reg) << cmd.div_bit;
    end

    // payload
    always_ff @(posedge aclk) begin
        fwd_addr_reg <= ram_waddr;
        fwd_data_reg <= ram_wdata;
        if (cmd.rd_en) begin
            rd_addr_reg <= ram_raddr;
            rd_slot_reg <= cmd.rd_slot;
        end
        if (cmd.load) begin
            item_reg <= s_data;
            for (int i = 0; i < 3; i++) begin
                addr_reg[i] <= AW'(idx_next[i]);
                ok_reg[i]   <= ok_next[i];
            end
        end
        if (cmd.rd_latch) begin
            rem_reg    <= cur.sum;
            quot_reg   <= '0;
            dcount_reg <= cur.count;
            dok_reg    <= ok_reg[0] && (cur.count != '0);
        end
        if (cmd.div_step) begin
            // sum < 256 * count, so eight restoring steps give the quotient
            for (int c = 0; c < 3; c++) begin
                if (rem_reg[c] >= trial) begin
                    rem_reg[c]                <= rem_reg[c] - trial;
                    quot_reg[c][cmd.div_bit]  <= 1'b1;
                end
            end
        end
        if (cmd.out_load) begin
            m_data_reg.vertex     <= item_reg.vertex_a;
            m_data_reg.avg_red    <= dok_reg ? quot_reg[2] : '0;
            m_data_reg.avg_green  <= dok_reg ? quot_reg[1] : '0;
            m_data_reg.avg_blue   <= dok_reg ? quot_reg[0] : '0;
            m_data_reg.face_count <= dok_reg ? fvca_pkg::FACE_W'(dcount_reg) : '0;
            m_data_reg.covered    <= dok_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

[sv/face_to_vertex_color_average_top.sv]
// Triangle item: states TRI_A, TRI_B and TRI_C run before the next accept, one memory read
//   and at most one write per vertex through the entry memory's read and write ports; no result.
// Read item: after accept the entry is latched and cleared, 8 restoring divider steps
//   follow, and the output load registers the result once the output is free; then s_ready returns.
// Reset initialises the control registers, then sweeps all VERTICES (4096) memory entries
//   to zero with s_ready low; configuration writes are taken during the sweep.
`default_nettype none
module face_to_vertex_color_average_top (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire fvca_pkg::in_item_t             s_data,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output fvca_pkg::out_item_t                 m_data,
    input  wire logic                           cfg_we,
    input  wire logic [fvca_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [fvca_pkg::CFG_W-1:0]     cfg_data
);

    fvca_pkg::cmd_t  cmd;
    fvca_pkg::stat_t stat;

    fvca_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    fvca_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule
`default_nettype wire
